// ===== src/gls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_pkg
// shared types and constants of the gain scheduled steering controller
// ----------------------------------------------------------------------------
package gls_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 32;

   localparam logic [30:0] MAX_STEER_RST = 31'd2293760;
   localparam logic [30:0] MATCH_TOL_RST = 31'd334;

   typedef enum logic [1:0] {
      CMD_COMPUTE = 2'd0,
      CMD_LOAD    = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_STEER = 1'b0,
      CSR_MATCH_TOL = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL2,
      ST_MUL3,
      ST_ACC,
      ST_SAT
   } back_state_type;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] beta2;
      logic signed [31:0] beta3;
      logic signed [31:0] gain2;
      logic signed [31:0] gain3;
   } point_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] desired;
      logic signed [31:0] meas_b2;
      logic signed [31:0] meas_b3;
      point_type          point;
   } item_type;

   typedef struct packed {
      logic [30:0] max_steer;
      logic [30:0] match_tol;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] steer_out;
      logic               matched;
      logic               saturated;
      logic               load_rejected;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/gls_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gls_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== src/gls_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_front
// accepts command transfers, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module gls_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         in_cmd,
   input  wire logic signed [31:0] in_desired,
   input  wire logic signed [31:0] in_meas_b2,
   input  wire logic signed [31:0] in_meas_b3,
   input  wire gls_pkg::point_type in_point,
   output logic                    q_valid,
   output gls_pkg::item_type       q_item,
   input  wire logic               q_pop
);
   import gls_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   item_type      entry_ff [QUEUE_DEPTH];
   item_type      new_item;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          push;
   logic          pop;

   assign busy    = (fill_ff == FW'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (fill_ff != '0);
   assign pop     = q_pop && q_valid;
   assign q_item  = entry_ff[rd_ptr_ff];

   // classify the command code
   always_comb begin
      new_item         = '0;
      new_item.desired = in_desired;
      new_item.meas_b2 = in_meas_b2;
      new_item.meas_b3 = in_meas_b3;
      new_item.point   = in_point;
      case (cmd_type'(in_cmd))
         CMD_COMPUTE: new_item.cmd = CMD_COMPUTE;
         CMD_LOAD:    new_item.cmd = CMD_LOAD;
         CMD_CLEAR:   new_item.cmd = CMD_CLEAR;
         default:     new_item.cmd = CMD_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

// ===== src/gls_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_back
// executes queued commands: table update, table scan, feedback and clipping
// ----------------------------------------------------------------------------
module gls_back #(
   parameter int TABLE_DEPTH = gls_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire gls_pkg::item_type q_item,
   output logic                   q_pop,
   input  wire gls_pkg::cfg_type  cfg,
   output gls_pkg::rsp_type       rsp
);
   import gls_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int PT_W = $bits(point_type);

   back_state_type     state_ff, state_in;

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      issued_ff;
   logic               rd_vld_ff;
   logic               table_full;
   logic               ram_we;
   logic               ram_re;
   logic [PT_W-1:0]    ram_rdata;
   point_type          rd_point;

   logic signed [31:0] desired_ff;
   logic signed [31:0] meas_b2_ff;
   logic signed [31:0] meas_b3_ff;
   logic signed [32:0] e2_ff, e3_ff;
   logic signed [31:0] g2_ff, g3_ff;
   logic               matched_ff;
   logic signed [64:0] prod_ff;
   logic signed [48:0] f2_ff;
   logic signed [48:0] f3;
   logic signed [50:0] sum_ff;

   logic signed [32:0] diff;
   logic        [32:0] diff_abs;
   logic               hit;
   logic               scan_done;
   logic signed [31:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [64:0] mul_p;
   logic signed [50:0] lim;
   logic signed [50:0] nlim;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [31:0] rsp_steer_ff;
   logic               rsp_matched_ff;
   logic               rsp_sat_ff;
   logic               rsp_rej_ff;

   gls_ram #(
      .WIDTH (PT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (q_item.point),
      .rd_en   (ram_re),
      .rd_addr (issued_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_point   = point_type'(ram_rdata);
   assign table_full = (count_ff == CW'(TABLE_DEPTH));

   // match window on the entry returned by the store
   assign diff      = 33'(rd_point.angle) - 33'(desired_ff);
   assign diff_abs  = diff[32] ? 33'(-diff) : 33'(diff);
   assign hit       = rd_vld_ff && (diff_abs < {2'b00, cfg.match_tol});
   assign scan_done = !rd_vld_ff && (issued_ff >= count_ff);

   // one shared multiplier for both gain terms
   assign mul_a = (state_ff == ST_MUL2) ? g2_ff : g3_ff;
   assign mul_b = (state_ff == ST_MUL2) ? e2_ff : e3_ff;
   assign mul_p = mul_a * mul_b;
   assign f3    = prod_ff[64:16];

   assign lim  = $signed({20'd0, cfg.max_steer});
   assign nlim = -lim;

   // result strobe: table and unused commands as they leave the queue, compute after clipping
   assign rsp_valid_in = (q_pop && (q_item.cmd != CMD_COMPUTE)) || (state_ff == ST_SAT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && (q_item.cmd == CMD_COMPUTE)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_MUL2;
            end else if (scan_done) begin
               state_in = ST_ACC;
            end
         end
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_ACC;
         ST_ACC:  state_in = ST_SAT;
         ST_SAT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop  = 1'b0;
      ram_re = 1'b0;
      case (state_ff)
         ST_IDLE: q_pop  = q_valid;
         ST_SCAN: ram_re = (issued_ff < count_ff) && !hit;
         default: begin
         end
      endcase
      ram_we = q_pop && (q_item.cmd == CMD_LOAD) && !table_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issued_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= ram_re;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_re) begin
            issued_ff <= issued_ff + 1'b1;
         end
         if (q_pop) begin
            issued_ff <= '0;
            case (q_item.cmd)
               CMD_LOAD: begin
                  if (!table_full) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
               CMD_CLEAR: begin
                  count_ff <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            desired_ff     <= q_item.desired;
            meas_b2_ff     <= q_item.meas_b2;
            meas_b3_ff     <= q_item.meas_b3;
            matched_ff     <= 1'b0;
            rsp_steer_ff   <= '0;
            rsp_matched_ff <= 1'b0;
            rsp_sat_ff     <= 1'b0;
            rsp_rej_ff     <= (q_item.cmd == CMD_LOAD) && table_full;
         end
         ST_SCAN: begin
            if (hit) begin
               e2_ff      <= 33'(meas_b2_ff) - 33'(rd_point.beta2);
               e3_ff      <= 33'(meas_b3_ff) - 33'(rd_point.beta3);
               g2_ff      <= rd_point.gain2;
               g3_ff      <= rd_point.gain3;
               matched_ff <= 1'b1;
            end else if (scan_done) begin
               prod_ff <= '0;
               f2_ff   <= '0;
            end
         end
         ST_MUL2: begin
            prod_ff <= mul_p;
         end
         ST_MUL3: begin
            f2_ff   <= prod_ff[64:16];
            prod_ff <= mul_p;
         end
         ST_ACC: begin
            sum_ff <= 51'(desired_ff) - 51'(f2_ff) - 51'(f3);
         end
         ST_SAT: begin
            rsp_matched_ff <= matched_ff;
            rsp_rej_ff     <= 1'b0;
            if (sum_ff > lim) begin
               rsp_steer_ff <= lim[31:0];
               rsp_sat_ff   <= 1'b1;
            end else if (sum_ff < nlim) begin
               rsp_steer_ff <= nlim[31:0];
               rsp_sat_ff   <= 1'b1;
            end else begin
               rsp_steer_ff <= sum_ff[31:0];
               rsp_sat_ff   <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.valid         = rsp_valid_ff;
      rsp.steer_out     = rsp_steer_ff;
      rsp.matched       = rsp_matched_ff;
      rsp.saturated     = rsp_sat_ff;
      rsp.load_rejected = rsp_rej_ff;
   end

endmodule
`default_nettype wire

// ===== src/gain_scheduled_lq_steer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gain_scheduled_lq_steer
// Gain scheduled LQ steering controller with a table of equilibrium points.
// Commands are taken on start while busy is low and go into a two entry
// queue, so a new command is usually taken while the previous one runs.
// Append, clear and unused commands show their result in the cycle after
// the one in which they leave the queue. A compute command scans the table
// one stored point per cycle through the registered read port of the point
// store and stops at the first point inside the match window; when nothing
// matches, it reads every stored point and both feedback terms are zero.
// On a match both gain products share one multiplier in the MUL2 and MUL3
// states before the sum and the clip.
// Each result is shown for one cycle with rsp_valid and cannot be held
// off. No clearing pass follows reset: the store is read only below the
// fill count. Configuration writes are always taken (csr_ready is high).
// ----------------------------------------------------------------------------
module gain_scheduled_lq_steer #(
   parameter int TABLE_DEPTH = gls_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_cmd,
   input  wire logic signed [31:0]               req_desired_angle,
   input  wire logic signed [31:0]               req_measured_beta2,
   input  wire logic signed [31:0]               req_measured_beta3,
   input  wire logic signed [31:0]               req_point_angle,
   input  wire logic signed [31:0]               req_point_beta2,
   input  wire logic signed [31:0]               req_point_beta3,
   input  wire logic signed [31:0]               req_point_gain2,
   input  wire logic signed [31:0]               req_point_gain3,
   output logic                                  rsp_valid,
   output logic signed [31:0]                    rsp_steer_out,
   output logic                                  rsp_matched,
   output logic                                  rsp_saturated,
   output logic                                  rsp_load_rejected,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [gls_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [gls_pkg::CSR_DATA_W-1:0]   csr_data
);
   import gls_pkg::*;

   cfg_type     cfg_ff;
   point_type   in_point;
   logic        q_valid;
   item_type    q_item;
   logic        q_pop;
   rsp_type     rsp;

   assign csr_ready = 1'b1;

   // configuration register transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_steer <= MAX_STEER_RST;
         cfg_ff.match_tol <= MATCH_TOL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_STEER: cfg_ff.max_steer <= csr_data[30:0];
            CSR_MATCH_TOL: cfg_ff.match_tol <= csr_data[30:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_point.angle = req_point_angle;
      in_point.beta2 = req_point_beta2;
      in_point.beta3 = req_point_beta3;
      in_point.gain2 = req_point_gain2;
      in_point.gain3 = req_point_gain3;
   end

   gls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .in_cmd     (req_cmd),
      .in_desired (req_desired_angle),
      .in_meas_b2 (req_measured_beta2),
      .in_meas_b3 (req_measured_beta3),
      .in_point   (in_point),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   gls_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .cfg     (cfg_ff),
      .rsp     (rsp)
   );

   assign rsp_valid         = rsp.valid;
   assign rsp_steer_out     = rsp.steer_out;
   assign rsp_matched       = rsp.matched;
   assign rsp_saturated     = rsp.saturated;
   assign rsp_load_rejected = rsp.load_rejected;

endmodule
`default_nettype wire
